/* rtl/ntw_pkg.sv */
package ntw_pkg;

   // Word codes.
   localparam logic [5:0] W_TWENTY_BASE = 6'd18;
   localparam logic [5:0] W_TEN         = 6'd10;
   localparam logic [5:0] W_HUNDRED     = 6'd28;
   localparam logic [5:0] W_THOUSAND    = 6'd29;
   localparam logic [5:0] W_MILLION     = 6'd30;
   localparam logic [5:0] W_BILLION     = 6'd31;
   localparam logic [5:0] W_TRILLION    = 6'd32;
   localparam logic [5:0] W_OH          = 6'd33;

   // Action codes.
   localparam logic [1:0] ACT_CARDINAL = 2'd0;
   localparam logic [1:0] ACT_ORDINAL  = 2'd1;
   localparam logic [1:0] ACT_YEAR     = 2'd2;

   localparam int VALUE_BITS = 60;
   localparam int DIGITS     = 18;
   localparam int GROUPS     = 6;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = 60'd999999999999999999;
   localparam logic [VALUE_BITS-1:0] YEAR_MIN  = 60'd1000;
   localparam logic [VALUE_BITS-1:0] YEAR_MAX  = 60'd9999;

   typedef struct packed {
      logic [1:0]            action;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [5:0] word;
      logic       ordinal_form;
      logic       last;
   } rsp_type;

   // One group of three digits with optional leading and trailing words.
   typedef struct packed {
      logic       pre_en;
      logic [5:0] pre_word;
      logic       speak;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
      logic       scale_en;
      logic [5:0] scale_word;
   } group_type;

   // Everything the back end needs to speak one request.
   typedef struct packed {
      group_type [GROUPS-1:0] grp;
      logic                   ordinal;
   } plan_type;

endpackage

/* rtl/ntw_front.sv */
module ntw_front
   import ntw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push,
   output plan_type push_plan,
   input  logic     fifo_full
);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_type;

   localparam int BCD_BITS = 4 * DIGITS;

   state_type               state_ff;
   logic [VALUE_BITS-1:0]   bin_ff;
   logic [BCD_BITS-1:0]     bcd_ff;
   logic [BCD_BITS-1:0]     bcd_adj;
   logic [5:0]              cnt_ff;
   logic                    year_ff;
   logic                    ord_ff;
   logic [VALUE_BITS-1:0]   sat_value;

   assign req_ready = (state_ff == ST_IDLE);
   assign sat_value = (req_data.value > VALUE_MAX) ? VALUE_MAX : req_data.value;

   // Double-dabble correction: add three to every digit of five or more.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // Build the speaking plan from the decimal digits.
   always_comb begin
      logic [5:0] nz;
      logic       year_pair;
      logic [3:0] d3, d2, d1, d0;
      for (int k = 0; k < GROUPS; k++) begin
         nz[k] = (bcd_ff[12*k +: 12] != 12'd0);
      end
      d3 = bcd_ff[15:12];
      d2 = bcd_ff[11:8];
      d1 = bcd_ff[7:4];
      d0 = bcd_ff[3:0];
      // Years 2000 through 2009 are read as plain numbers.
      year_pair = year_ff && !(d3 == 4'd2 && d2 == 4'd0 && d1 == 4'd0);
      push_plan.ordinal = ord_ff;
      for (int k = 0; k < GROUPS; k++) begin
         push_plan.grp[k].pre_en     = 1'b0;
         push_plan.grp[k].pre_word   = W_HUNDRED;
         push_plan.grp[k].speak      = nz[k];
         push_plan.grp[k].hund       = bcd_ff[12*k+8 +: 4];
         push_plan.grp[k].tens       = bcd_ff[12*k+4 +: 4];
         push_plan.grp[k].ones       = bcd_ff[12*k +: 4];
         push_plan.grp[k].scale_en   = 1'b0;
         push_plan.grp[k].scale_word = W_THOUSAND;
      end
      if (year_pair) begin
         push_plan.grp[1].hund  = 4'd0;
         push_plan.grp[1].tens  = d3;
         push_plan.grp[1].ones  = d2;
         push_plan.grp[1].speak = 1'b1;
         push_plan.grp[0].hund  = 4'd0;
         push_plan.grp[0].tens  = d1;
         push_plan.grp[0].ones  = d0;
         if (d1 == 4'd0 && d0 == 4'd0) begin
            push_plan.grp[0].pre_en = 1'b1;
            push_plan.grp[0].speak  = 1'b0;
         end else if (d1 == 4'd0) begin
            push_plan.grp[0].pre_en   = 1'b1;
            push_plan.grp[0].pre_word = W_OH;
         end
      end else begin
         // A value of zero is spoken as the lone word zero.
         push_plan.grp[0].speak      = (nz == 6'd0) || nz[0];
         push_plan.grp[5].scale_en   = nz[5];
         push_plan.grp[4].scale_en   = nz[5] || nz[4];
         push_plan.grp[4].scale_word = W_TRILLION;
         push_plan.grp[3].scale_en   = nz[3];
         push_plan.grp[3].scale_word = W_BILLION;
         push_plan.grp[2].scale_en   = nz[2];
         push_plan.grp[2].scale_word = W_MILLION;
         push_plan.grp[1].scale_en   = nz[1];
      end
   end

   assign push = (state_ff == ST_PUSH) && !fifo_full;

   // Sequencer: accept, convert one bit per cycle, hand the plan over.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  bin_ff   <= sat_value;
                  bcd_ff   <= '0;
                  cnt_ff   <= '0;
                  ord_ff   <= (req_data.action == ACT_ORDINAL);
                  year_ff  <= (req_data.action == ACT_YEAR) &&
                              sat_value >= YEAR_MIN && sat_value <= YEAR_MAX;
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               bcd_ff <= {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
               bin_ff <= {bin_ff[VALUE_BITS-2:0], 1'b0};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(VALUE_BITS - 1)) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!fifo_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* rtl/ntw_fifo.sv */
module ntw_fifo
   import ntw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  plan_type push_plan,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output plan_type head
);

   plan_type   mem_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_plan;
      end
   end

   // Two-entry queue between the converter and the word sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

/* rtl/ntw_back.sv */
module ntw_back
   import ntw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  plan_type head,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_type;
   typedef enum logic [2:0] {PH_PRE, PH_HDIGIT, PH_HWORD, PH_TENS, PH_ONES, PH_SCALE}
      phase_type;

   state_type  state_ff;
   phase_type  ph_ff;
   logic [2:0] grp_ff;
   logic       pend_valid_ff;
   logic [5:0] pend_word_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   group_type  cur;
   logic       tok_en;
   logic [5:0] tok_word;
   logic       out_free;
   logic       stall;
   logic       emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur       = head.grp[grp_ff];
   assign stall     = tok_en && pend_valid_ff && !out_free;
   assign pop       = (state_ff == ST_FLUSH) && out_free;

   // A word leaves the hold register when a newer word arrives or at the flush.
   assign emit = ((state_ff == ST_RUN) && !stall && tok_en && pend_valid_ff) || pop;

   // Word, if any, at the current step of the current group.
   always_comb begin
      tok_en   = 1'b0;
      tok_word = {2'b00, cur.ones};
      case (ph_ff)
         PH_PRE: begin
            tok_en   = cur.pre_en;
            tok_word = cur.pre_word;
         end
         PH_HDIGIT: begin
            tok_en   = cur.speak && cur.hund != 4'd0;
            tok_word = {2'b00, cur.hund};
         end
         PH_HWORD: begin
            tok_en   = cur.speak && cur.hund != 4'd0;
            tok_word = W_HUNDRED;
         end
         PH_TENS: begin
            // A whole hundred ends after the word hundred.
            tok_en = cur.speak &&
                     !(cur.hund != 4'd0 && cur.tens == 4'd0 && cur.ones == 4'd0);
            if (cur.tens >= 4'd2) begin
               tok_word = W_TWENTY_BASE + {2'b00, cur.tens};
            end else if (cur.tens == 4'd1) begin
               tok_word = W_TEN + {2'b00, cur.ones};
            end else begin
               tok_word = {2'b00, cur.ones};
            end
         end
         PH_ONES: begin
            tok_en   = cur.speak && cur.tens >= 4'd2 && cur.ones != 4'd0;
            tok_word = {2'b00, cur.ones};
         end
         PH_SCALE: begin
            tok_en   = cur.scale_en;
            tok_word = cur.scale_word;
         end
         default: begin
            tok_en = 1'b0;
         end
      endcase
   end

   // Word sequencer with a one-word hold so the final word can carry last.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ph_ff         <= PH_PRE;
         grp_ff        <= 3'd0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  grp_ff   <= 3'(GROUPS - 1);
                  ph_ff    <= PH_PRE;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (!stall) begin
                  if (tok_en) begin
                     if (pend_valid_ff) begin
                        rsp_ff.word          <= pend_word_ff;
                        rsp_ff.ordinal_form  <= 1'b0;
                        rsp_ff.last          <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_word_ff  <= tok_word;
                  end
                  if (ph_ff == PH_SCALE) begin
                     ph_ff <= PH_PRE;
                     if (grp_ff == 3'd0) begin
                        state_ff <= ST_FLUSH;
                     end else begin
                        grp_ff <= grp_ff - 3'd1;
                     end
                  end else begin
                     ph_ff <= phase_type'(ph_ff + 3'd1);
                  end
               end
            end
            ST_FLUSH: begin
               if (out_free) begin
                  rsp_ff.word         <= pend_word_ff;
                  rsp_ff.ordinal_form <= head.ordinal;
                  rsp_ff.last         <= 1'b1;
                  pend_valid_ff       <= 1'b0;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* rtl/number_to_word_tokens_top.sv */
// Speaks an unsigned number below ten to the eighteenth as English word
// tokens, one response per word with last set on the final word. Action 0
// reads a cardinal, 1 an ordinal (final word flagged), 2 a year in
// 1000..9999; other values and action 3 read as cardinals, and values too
// large saturate to 999999999999999999. The front end converts binary to
// decimal one bit per cycle and takes no new request until its plan is in
// the queue; the word sequencer, held by any output stalls, overlaps with
// the next conversion through a two-entry queue.
module number_to_word_tokens_top
   import ntw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     push;
   logic     pop;
   logic     full;
   logic     empty;
   plan_type push_plan;
   plan_type head;

   ntw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_plan (push_plan),
      .fifo_full (full)
   );

   ntw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (push_plan),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   ntw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* dv/tb_number_to_word_tokens_top.sv */
module tb_number_to_word_tokens_top
   import ntw_pkg::*;
();

   // Holds the word runs still owed by the block and checks each response.
   class word_scoreboard;
      rsp_type owed_words[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // Speaks a group below one thousand.
      function void speak_group(int unsigned n, ref logic [5:0] run[$]);
         n = n % 1000;
         if (n >= 100) begin
            run.push_back(6'(n / 100));
            run.push_back(W_HUNDRED);
            n = n % 100;
            if (n == 0) return;
         end
         if (n < 20) begin
            run.push_back(6'(n));
            return;
         end
         run.push_back(6'(W_TWENTY_BASE + n / 10));
         if (n % 10 != 0) run.push_back(6'(n % 10));
      endfunction

      // Speaks any value, splitting off scale groups recursively.
      function automatic void speak_number(longint unsigned n, ref logic [5:0] run[$]);
         longint unsigned scale[4];
         logic [5:0]      scale_name[4];
         scale = '{64'd1000000000000, 64'd1000000000, 64'd1000000, 64'd1000};
         scale_name = '{W_TRILLION, W_BILLION, W_MILLION, W_THOUSAND};
         if (n == 0) begin
            run.push_back(6'd0);
            return;
         end
         for (int i = 0; i < 4; i++) begin
            if (n >= scale[i]) begin
               speak_number(n / scale[i], run);
               run.push_back(scale_name[i]);
               n = n % scale[i];
               if (n == 0) return;
            end
         end
         speak_group(int'(n), run);
      endfunction

      // Works out the run for one accepted request.
      function void note_request(req_type r);
         logic [5:0]      run[$];
         longint unsigned v;
         int unsigned     hi, lo;
         rsp_type         w;
         v = 64'(r.value);
         if (v > 64'(VALUE_MAX)) v = 64'(VALUE_MAX);
         if (r.action == ACT_YEAR && v >= 1000 && v <= 9999) begin
            hi = int'(v) / 100;
            lo = int'(v) % 100;
            if (v >= 2000 && v < 2010) begin
               speak_number(v, run);
            end else begin
               speak_group(hi, run);
               if (lo == 0) begin
                  run.push_back(W_HUNDRED);
               end else begin
                  if (lo < 10) run.push_back(W_OH);
                  speak_group(lo, run);
               end
            end
         end else begin
            speak_number(v, run);
         end
         foreach (run[k]) begin
            w.word = run[k];
            w.last = (k == run.size() - 1);
            w.ordinal_form = w.last && (r.action == ACT_ORDINAL);
            owed_words.push_back(w);
         end
      endfunction

      // Compares one response with the oldest owed word.
      function void check_word(rsp_type got);
         rsp_type want;
         if (owed_words.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = owed_words.pop_front();
         if (got.word !== want.word || got.ordinal_form !== want.ordinal_form ||
             got.last !== want.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   word_scoreboard board = new();
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   number_to_word_tokens_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Note requests and check responses at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_word(rsp_data);
   end

   // The receiver stalls at random.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Sends one request and holds it until it is taken.
   task automatic send_request(logic [1:0] act, logic [VALUE_BITS-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_data <= '{action: act, value: val};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Mostly small and mid-size numbers, some large ones, and full-width noise.
   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(7))
         0: v = $urandom_range(999);
         1: v = $urandom_range(9999, 1000);
         2: v = $urandom_range(999999);
         3: v = {$urandom, $urandom} % 64'd1000000000000;
         4: v = {$urandom, $urandom} % 64'd1000000000000000000;
         5: v = {$urandom, $urandom};
         6: v = 64'd1000 ** $urandom_range(5) * $urandom_range(999, 1);
         default: v = $urandom_range(2100, 1000);
      endcase
      return v[VALUE_BITS-1:0];
   endfunction

   task automatic run_random(int count);
      logic [1:0] act;
      for (int i = 0; i < count; i++) begin
         act = 2'($urandom_range(3));
         send_request(act, pick_value());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases: zero, extremes, saturation, every action and year forms.
      send_request(ACT_CARDINAL, 60'd0);
      send_request(ACT_ORDINAL, 60'd0);
      send_request(ACT_CARDINAL, VALUE_MAX);
      send_request(ACT_ORDINAL, VALUE_MAX);
      send_request(ACT_CARDINAL, VALUE_MAX + 60'd1);
      send_request(ACT_YEAR, '1);
      send_request(2'd3, 60'd1234567);
      send_request(ACT_CARDINAL, 60'd1000000000000000);
      send_request(ACT_CARDINAL, 60'd100);
      send_request(ACT_ORDINAL, 60'd19);
      send_request(ACT_CARDINAL, 60'd1001001001);
      send_request(ACT_YEAR, YEAR_MIN);
      send_request(ACT_YEAR, 60'd1005);
      send_request(ACT_YEAR, 60'd1999);
      send_request(ACT_YEAR, 60'd1900);
      send_request(ACT_YEAR, 60'd2000);
      send_request(ACT_YEAR, 60'd2009);
      send_request(ACT_YEAR, 60'd2010);
      send_request(ACT_YEAR, YEAR_MAX);
      send_request(ACT_YEAR, 60'd999);
      send_request(ACT_YEAR, 60'd10000);
      send_request(ACT_YEAR, 60'd1915);

      // Random phases with three idling patterns.
      sender_idle_pct = 36;
      receiver_idle_pct = 78;
      run_random(135);
      sender_idle_pct = 78;
      receiver_idle_pct = 36;
      run_random(135);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      run_random(140);

      while (board.owed_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // Timeout.
   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
